### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sampler block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("property failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### hw/rtl/wcts_pkg.sv
// Types, constants and helper functions of the weighted count table sampler.
`default_nettype none
package wcts_pkg;
	localparam int NUM_SLOTS   = 16;
	localparam int COUNT_WIDTH = 32;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);
	localparam int WALK_W      = SLOT_W + 1;
	localparam int OP_W        = 3;
	localparam int IDX_W       = 4;
	localparam int IDX_EXT_W   = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
	localparam int WEIGHT_W    = 32;
	localparam int PROB_W      = 17;
	localparam int RAND_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int CNT_OUT_W   = 32;
	localparam int TOTAL_W     = 36;
	localparam int CHOSEN_W    = 4;
	localparam int SCALE_W     = 16;
	localparam int SUM_W       = COUNT_WIDTH + SLOT_W;
	localparam int ACC_W       = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
	localparam int ADD_W       = 33;
	localparam int NUM_W       = ((COUNT_WIDTH + 16 > TOTAL_W - 1) ?
		(COUNT_WIDTH + 16) : (TOTAL_W - 1)) + 1;
	localparam int REM_W       = TOTAL_W + 1;
	localparam int DIV_CNT_W   = $clog2(PROB_W);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
	localparam logic [TOTAL_W-1:0]     TOTAL_MAX   = '1;
	localparam logic [SCALE_W-1:0]     SCALE_RESET = 16'd1000;
	localparam logic                   REG_SCALE   = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_SLOT   = 3'd0,
		OP_ADD_WEIGHT = 3'd1,
		OP_ADD_ONE    = 3'd2,
		OP_ADD_SCALED = 3'd3,
		OP_DELETE     = 3'd4,
		OP_QUERY      = 3'd5,
		OP_SAMPLE     = 3'd6,
		OP_SET_COUNT  = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic issue_read;
		logic execute;
		logic walk;
		logic divide;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_walk;
		logic need_div;
		logic walk_hit;
		logic walk_end;
		logic div_done;
	} dp_sts_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_count(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [ADD_W-1:0]       b
	);
		logic [ADD_W:0] sum;
		sum = (ADD_W+1)'(a) + (ADD_W+1)'(b);
		return (sum > (ADD_W+1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_total(input logic [ACC_W-1:0] raw);
		return (raw > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : raw[TOTAL_W-1:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] clamp_weight(input logic [WEIGHT_W-1:0] w);
		return (w > WEIGHT_W'(COUNT_MAX)) ? COUNT_MAX : w[COUNT_WIDTH-1:0];
	endfunction
endpackage
`default_nettype wire

### hw/rtl/wcts_in_if.sv
// Input item channel: operation request with valid/ready.
`default_nettype none
interface wcts_in_if;
	logic                          valid;
	logic                          ready;
	logic [wcts_pkg::OP_W-1:0]     operation;
	logic [wcts_pkg::IDX_W-1:0]    state_index;
	logic [wcts_pkg::WEIGHT_W-1:0] weight;
	logic [wcts_pkg::PROB_W-1:0]   probability_q16;
	logic [wcts_pkg::RAND_W-1:0]   random_value;

	modport source (output valid, operation, state_index, weight, probability_q16,
		random_value, input ready);
	modport sink (input valid, operation, state_index, weight, probability_q16,
		random_value, output ready);
endinterface
`default_nettype wire

### hw/rtl/wcts_out_if.sv
// Result channel: status, counts, probability and chosen slot with valid/ready.
`default_nettype none
interface wcts_out_if;
	logic                           valid;
	logic                           ready;
	logic [wcts_pkg::STATUS_W-1:0]  status;
	logic [wcts_pkg::CNT_OUT_W-1:0] slot_count;
	logic [wcts_pkg::TOTAL_W-1:0]   total_count;
	logic [wcts_pkg::PROB_W-1:0]    probability_out;
	logic [wcts_pkg::CHOSEN_W-1:0]  chosen_index;

	modport source (output valid, status, slot_count, total_count, probability_out,
		chosen_index, input ready);
	modport sink (input valid, status, slot_count, total_count, probability_out,
		chosen_index, output ready);
endinterface
`default_nettype wire

### hw/rtl/wcts_regs.sv
// APB register block holding the probability weight scale.
`default_nettype none
module wcts_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [wcts_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wcts_pkg::PDATA_W-1:0] pwdata,
	output logic      [wcts_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	output logic      [wcts_pkg::SCALE_W-1:0] weight_scale
);
	logic [wcts_pkg::SCALE_W-1:0] scale_q;
	logic                         reg_sel;

	assign reg_sel = (paddr[2] == wcts_pkg::REG_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= wcts_pkg::SCALE_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			scale_q <= pwdata[wcts_pkg::SCALE_W-1:0];
		end
	end

	assign prdata       = reg_sel ? wcts_pkg::PDATA_W'(scale_q) : '0;
	assign pready       = 1'b1;
	assign weight_scale = scale_q;
endmodule
`default_nettype wire

### hw/rtl/wcts_ctl.sv
// Sequencer of the sampler: steps each item through read, execute, walk or divide.
`default_nettype none
`include "assert_macros.svh"
module wcts_ctl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire wcts_pkg::dp_sts_t  sts,
	output wcts_pkg::ctl_cmd_t      cmd
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_EXEC = 6'b000100,
		S_WALK = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_nx = S_READ;
			end
			S_READ: begin
				cmd.issue_read = 1'b1;
				state_nx       = S_EXEC;
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				if (sts.need_walk) state_nx = S_WALK;
				else if (sts.need_div) state_nx = S_DIV;
				else state_nx = S_DONE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_hit || sts.walk_end) state_nx = S_DONE;
			end
			S_DIV: begin
				cmd.divide = 1'b1;
				if (sts.div_done) state_nx = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`ASSERT_PROP(a_accept_reads, clk, arst_n, in_valid && in_ready |=> state_q == S_READ)
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.load_out && out_valid_q && !out_ready)
endmodule
`default_nettype wire

### hw/rtl/wcts_dp.sv
// Datapath: slot count memory, present bits, total, prefix walk and serial divider.
`default_nettype none
`include "assert_macros.svh"
module wcts_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire wcts_pkg::ctl_cmd_t             cmd,
	output wcts_pkg::dp_sts_t                   sts,
	input  wire logic [wcts_pkg::OP_W-1:0]      operation,
	input  wire logic [wcts_pkg::IDX_W-1:0]     state_index,
	input  wire logic [wcts_pkg::WEIGHT_W-1:0]  weight,
	input  wire logic [wcts_pkg::PROB_W-1:0]    probability_q16,
	input  wire logic [wcts_pkg::RAND_W-1:0]    random_value,
	input  wire logic [wcts_pkg::SCALE_W-1:0]   weight_scale,
	output logic      [wcts_pkg::STATUS_W-1:0]  status,
	output logic      [wcts_pkg::CNT_OUT_W-1:0] slot_count,
	output logic      [wcts_pkg::TOTAL_W-1:0]   total_count,
	output logic      [wcts_pkg::PROB_W-1:0]    probability_out,
	output logic      [wcts_pkg::CHOSEN_W-1:0]  chosen_index
);
	// captured item
	wcts_pkg::op_t                         op_q;
	logic [wcts_pkg::IDX_EXT_W-1:0]        idx_q;
	logic [wcts_pkg::COUNT_WIDTH-1:0]      w_q;
	logic [wcts_pkg::PROB_W-1:0]           p_q;
	logic [wcts_pkg::RAND_W-1:0]           draw_q;

	// table state
	logic [wcts_pkg::COUNT_WIDTH-1:0]      cnt_mem [wcts_pkg::NUM_SLOTS];
	logic [wcts_pkg::NUM_SLOTS-1:0]        present_q;
	logic [wcts_pkg::ACC_W-1:0]            raw_q;

	// memory read stage
	logic [wcts_pkg::COUNT_WIDTH-1:0]      rd_data_s1;
	logic [wcts_pkg::SLOT_W-1:0]           rd_idx_s1;
	logic                                  rd_vld_s1;

	logic [63:0]                           prod_q;
	logic [wcts_pkg::TOTAL_W-1:0]          r_q;
	logic [wcts_pkg::WALK_W-1:0]           walk_q;
	logic [wcts_pkg::SUM_W-1:0]            cum_q;
	logic [wcts_pkg::REM_W-1:0]            rem_q;
	logic [wcts_pkg::PROB_W-1:0]           nlo_q;
	logic [wcts_pkg::PROB_W-1:0]           quo_q;
	logic [wcts_pkg::DIV_CNT_W-1:0]        div_cnt_q;

	wcts_pkg::status_t                     res_status_q;
	logic [wcts_pkg::COUNT_WIDTH-1:0]      res_cnt_q;
	logic [wcts_pkg::SLOT_W-1:0]           res_chosen_q;

	logic [wcts_pkg::STATUS_W-1:0]         status_q;
	logic [wcts_pkg::CNT_OUT_W-1:0]        slot_count_q;
	logic [wcts_pkg::TOTAL_W-1:0]          total_q;
	logic [wcts_pkg::PROB_W-1:0]           prob_q;
	logic [wcts_pkg::CHOSEN_W-1:0]         chosen_q;

	// combinational
	logic                                  idx_ok;
	logic [wcts_pkg::SLOT_W-1:0]           slot_a;
	logic                                  here;
	logic [wcts_pkg::TOTAL_W-1:0]          total;
	logic                                  total_zero;
	logic                                  rd_en;
	logic [wcts_pkg::SLOT_W-1:0]           rd_addr;
	logic [31:0]                           mul_a, mul_b;
	logic [33:0]                           sw_sum;
	logic [17:0]                           sw;
	logic [wcts_pkg::TOTAL_W:0]            r_sum;
	logic [wcts_pkg::COUNT_WIDTH-1:0]      new_cnt, old_term, new_term, cnt_x;
	logic                                  mem_we, set_pres, clr_pres;
	wcts_pkg::status_t                     status_x;
	logic [wcts_pkg::ACC_W-1:0]            raw_nx;
	logic [wcts_pkg::NUM_W-1:0]            num;
	logic                                  walk_pres;
	logic [wcts_pkg::SUM_W-1:0]            cum_nx;
	logic [wcts_pkg::REM_W-1:0]            trial, divisor;
	logic                                  ge;
	logic [wcts_pkg::IDX_EXT_W-1:0]        chosen_ext;

	assign idx_ok     = ({1'b0, idx_q} < (wcts_pkg::IDX_EXT_W+1)'(wcts_pkg::NUM_SLOTS));
	assign slot_a     = idx_q[wcts_pkg::SLOT_W-1:0];
	assign here       = idx_ok && present_q[slot_a];
	assign total      = wcts_pkg::sat_total(raw_q);
	assign total_zero = (total == '0);

	assign rd_addr = cmd.walk ? walk_q[wcts_pkg::SLOT_W-1:0] : slot_a;
	assign rd_en   = cmd.issue_read ||
		(cmd.walk && (walk_q < wcts_pkg::WALK_W'(wcts_pkg::NUM_SLOTS)));

	// shared multiplier: p*scale for scaled add, draw*total_low for sampling
	assign mul_a = (op_q == wcts_pkg::OP_SAMPLE) ? draw_q : 32'(p_q);
	assign mul_b = (op_q == wcts_pkg::OP_SAMPLE) ? total[31:0] : 32'(weight_scale);

	assign sw_sum = prod_q[33:0] + 34'd32768;
	assign sw     = sw_sum[33:16];
	assign r_sum  = (wcts_pkg::TOTAL_W+1)'(draw_q) *
			(wcts_pkg::TOTAL_W+1)'(total[wcts_pkg::TOTAL_W-1:32]) +
		(wcts_pkg::TOTAL_W+1)'(prod_q[63:32]);

	always_comb begin
		new_cnt  = '0;
		old_term = '0;
		new_term = '0;
		cnt_x    = '0;
		mem_we   = 1'b0;
		set_pres = 1'b0;
		clr_pres = 1'b0;
		status_x = wcts_pkg::ST_OK;
		if (op_q == wcts_pkg::OP_ADD_SLOT) begin
			if (!idx_ok) begin
				status_x = wcts_pkg::ST_ABSENT;
			end else if (here) begin
				status_x = wcts_pkg::ST_PRESENT;
				cnt_x    = rd_data_s1;
			end else begin
				new_cnt  = w_q;
				new_term = w_q;
				cnt_x    = w_q;
				mem_we   = 1'b1;
				set_pres = 1'b1;
			end
		end else if (op_q == wcts_pkg::OP_SAMPLE) begin
			if (total_zero) status_x = wcts_pkg::ST_EMPTY;
		end else if (!here) begin
			status_x = wcts_pkg::ST_ABSENT;
		end else begin
			case (op_q)
				wcts_pkg::OP_ADD_WEIGHT:
					new_cnt = wcts_pkg::sat_count(rd_data_s1, wcts_pkg::ADD_W'(w_q));
				wcts_pkg::OP_ADD_ONE:
					new_cnt = wcts_pkg::sat_count(rd_data_s1, wcts_pkg::ADD_W'(1));
				wcts_pkg::OP_ADD_SCALED:
					new_cnt = wcts_pkg::sat_count(rd_data_s1, wcts_pkg::ADD_W'(sw));
				wcts_pkg::OP_SET_COUNT:
					new_cnt = w_q;
				default:
					new_cnt = '0;
			endcase
			case (op_q)
				wcts_pkg::OP_QUERY: begin
					cnt_x = rd_data_s1;
					if (total_zero) status_x = wcts_pkg::ST_EMPTY;
				end
				wcts_pkg::OP_DELETE: begin
					mem_we   = 1'b1;
					clr_pres = 1'b1;
					old_term = rd_data_s1;
				end
				default: begin
					mem_we   = 1'b1;
					old_term = rd_data_s1;
					new_term = new_cnt;
					cnt_x    = new_cnt;
				end
			endcase
		end
	end

	assign raw_nx = raw_q - wcts_pkg::ACC_W'(old_term) + wcts_pkg::ACC_W'(new_term);
	assign num    = wcts_pkg::NUM_W'({rd_data_s1, 16'b0}) + wcts_pkg::NUM_W'(total >> 1);

	assign walk_pres = present_q[rd_idx_s1];
	assign cum_nx    = cum_q + (walk_pres ? wcts_pkg::SUM_W'(rd_data_s1) : '0);

	assign divisor = wcts_pkg::REM_W'(total);
	assign trial   = {rem_q[wcts_pkg::TOTAL_W-1:0], nlo_q[wcts_pkg::PROB_W-1]};
	assign ge      = (trial >= divisor);

	always_comb begin
		sts           = '0;
		sts.need_walk = cmd.execute && (op_q == wcts_pkg::OP_SAMPLE) && !total_zero;
		sts.need_div  = cmd.execute && (op_q == wcts_pkg::OP_QUERY) && here && !total_zero;
		sts.walk_hit  = cmd.walk && rd_vld_s1 && walk_pres &&
			(wcts_pkg::ACC_W'(cum_nx) > wcts_pkg::ACC_W'(r_q));
		sts.walk_end  = cmd.walk && rd_vld_s1 &&
			(rd_idx_s1 == wcts_pkg::SLOT_W'(wcts_pkg::NUM_SLOTS - 1));
		sts.div_done  = cmd.divide &&
			(div_cnt_q == wcts_pkg::DIV_CNT_W'(wcts_pkg::PROB_W - 1));
	end

	// count memory
	always_ff @(posedge clk) begin
		if (cmd.execute && mem_we) cnt_mem[slot_a] <= new_cnt;
		if (rd_en) rd_data_s1 <= cnt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			raw_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.execute) begin
				raw_q     <= raw_nx;
				rd_vld_s1 <= 1'b0;
				if (set_pres) present_q[slot_a] <= 1'b1;
				if (clr_pres) present_q[slot_a] <= 1'b0;
			end else if (cmd.walk) begin
				rd_vld_s1 <= rd_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= wcts_pkg::op_t'(operation);
			idx_q  <= wcts_pkg::IDX_EXT_W'(state_index);
			w_q    <= wcts_pkg::clamp_weight(weight);
			p_q    <= probability_q16;
			draw_q <= random_value;
		end
		if (cmd.issue_read) prod_q <= 64'(mul_a) * 64'(mul_b);
		if (cmd.execute) begin
			r_q          <= r_sum[wcts_pkg::TOTAL_W-1:0];
			walk_q       <= '0;
			cum_q        <= '0;
			quo_q        <= '0;
			div_cnt_q    <= '0;
			rem_q        <= wcts_pkg::REM_W'(num[wcts_pkg::NUM_W-1:wcts_pkg::PROB_W]);
			nlo_q        <= num[wcts_pkg::PROB_W-1:0];
			res_status_q <= status_x;
			res_cnt_q    <= cnt_x;
			res_chosen_q <= '0;
		end
		if (cmd.walk) begin
			if (rd_en) begin
				walk_q    <= walk_q + 1'b1;
				rd_idx_s1 <= walk_q[wcts_pkg::SLOT_W-1:0];
			end
			if (rd_vld_s1) cum_q <= cum_nx;
			if (sts.walk_hit) begin
				res_chosen_q <= rd_idx_s1;
				res_cnt_q    <= rd_data_s1;
			end
		end
		if (cmd.divide) begin
			rem_q     <= ge ? (trial - divisor) : trial;
			quo_q     <= {quo_q[wcts_pkg::PROB_W-2:0], ge};
			nlo_q     <= {nlo_q[wcts_pkg::PROB_W-2:0], 1'b0};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (cmd.load_out) begin
			status_q     <= res_status_q;
			slot_count_q <= wcts_pkg::CNT_OUT_W'(res_cnt_q);
			total_q      <= total;
			prob_q       <= quo_q;
			chosen_q     <= chosen_ext[wcts_pkg::CHOSEN_W-1:0];
		end
	end

	assign chosen_ext = wcts_pkg::IDX_EXT_W'(res_chosen_q);

	assign status          = status_q;
	assign slot_count      = slot_count_q;
	assign total_count     = total_q;
	assign probability_out = prob_q;
	assign chosen_index    = chosen_q;

	`ASSERT_NEVER(a_walk_finds, clk, arst_n, sts.walk_end && !sts.walk_hit)
	`ASSERT_PROP(a_div_rem_below, clk, arst_n, cmd.divide |-> rem_q < divisor)
endmodule
`default_nettype wire

### hw/rtl/weighted_count_table_sampler_unit.sv
// Weighted count table sampler: top level joining registers, sequencer and datapath.
//
// Items arrive on the item channel (valid/ready); each transfer runs one operation
// on a table of 16 slots (add, add weight, add one, add scaled probability, set,
// delete, query, sample) and yields exactly one transfer on the result channel.
// The APB port holds weight_scale at byte address 0; pready is always high.
// Steps from item transfer to result valid:
//   update and add operations, absent slots and zero total: read, execute, done;
//   the next item is taken only after this result is loaded for output;
//   query with nonzero total: read, execute, then a 17-step restoring divider;
//   sample: read, execute, then a prefix walk reading one slot of the count memory
//   per cycle until the chosen slot is found.
// The block takes a new item while a finished result still waits in the output
// register; when the receiver stalls, the next result waits inside until the
// output register frees up, and no further item is taken meanwhile.
// Reset (arst_n low) marks all slots absent, clears the total and the handshakes, and sets
// weight_scale to 1000; no clearing pass is needed.
`default_nettype none
module weighted_count_table_sampler_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	wcts_in_if.sink                           item,
	wcts_out_if.source                        result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [wcts_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wcts_pkg::PDATA_W-1:0] pwdata,
	output logic      [wcts_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);
	wcts_pkg::ctl_cmd_t           cmd;
	wcts_pkg::dp_sts_t            sts;
	logic [wcts_pkg::SCALE_W-1:0] weight_scale;

	wcts_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.weight_scale (weight_scale)
	);

	wcts_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wcts_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (item.operation),
		.state_index     (item.state_index),
		.weight          (item.weight),
		.probability_q16 (item.probability_q16),
		.random_value    (item.random_value),
		.weight_scale    (weight_scale),
		.status          (result.status),
		.slot_count      (result.slot_count),
		.total_count     (result.total_count),
		.probability_out (result.probability_out),
		.chosen_index    (result.chosen_index)
	);
endmodule
`default_nettype wire
